/* sv/passive_joint_torque_unit_assert.svh */
// Assertion macros used by the checker file.
`ifndef PASSIVE_JOINT_TORQUE_UNIT_ASSERT_SVH
`define PASSIVE_JOINT_TORQUE_UNIT_ASSERT_SVH

// Overlapping implication, sampled on clk, off while in reset.
`define PJT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pjt assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define PJT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pjt assertion failed");

`endif

/* sv/pjt_pkg.sv */
`default_nettype none
package pjt_pkg;

	typedef struct packed {
		logic signed [15:0] joint_angle;
		logic signed [15:0] joint_speed;
	} pjt_item_t;

	typedef struct packed {
		logic signed [31:0] torque;
		logic               saturated;
	} pjt_result_t;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_UPPER_SLOPE   = 3'd0;
	localparam logic [2:0] REG_UPPER_LIMIT   = 3'd1;
	localparam logic [2:0] REG_LOWER_SLOPE   = 3'd2;
	localparam logic [2:0] REG_LOWER_LIMIT   = 3'd3;
	localparam logic [2:0] REG_TORQUE_OFFSET = 3'd4;
	localparam logic [2:0] REG_DAMPING_GAIN  = 3'd5;

	localparam int PJT_LATENCY = 32;

	// round(2^32 * pi / 11520): 1/64 degree to radians, Q.32
	localparam logic [20:0] DEG64_TO_RAD = 21'd1171271;
	localparam logic [39:0] LN2_Q40      = 40'hB17217F7D2;
	// floor(2^16 / ln2), for the quotient estimate
	localparam logic [16:0] RECIP_LN2    = 17'd94548;
	localparam logic signed [55:0] ARG_MAX = 56'sd13194139533312;
	// 18 * ln2 in Q.40 keeps the reduced argument positive
	localparam logic signed [55:0] XP_BIAS = 56'sd13718220926148;

	localparam int SER_STEPS = 11;

	// exact floor(v/k) for 32-bit v: (v * DIV_MUL[k]) >> DIV_SH[k]
	localparam logic [32:0] DIV_MUL [13] = '{
		33'd0, 33'd4294967297, 33'd4294967297, 33'd5726623062, 33'd4294967297,
		33'd6871947674, 33'd5726623062, 33'd4908534053, 33'd4294967297,
		33'd7635497416, 33'd6871947674, 33'd6247225158, 33'd5726623062};
	localparam logic [5:0] DIV_SH [13] = '{
		6'd32, 6'd32, 6'd33, 6'd34, 6'd34, 6'd35, 6'd35, 6'd35, 6'd35,
		6'd36, 6'd36, 6'd36, 6'd36};

endpackage
`default_nettype wire

/* sv/passive_joint_torque_unit.sv */
// Passive joint torque: one request may start in every cycle; busy never rises.
// Pipeline: 7 front stages, 22 series stages, then scale, sum and clamp; done and the
// result are registered together, in the same cycle.
// Throughput: one request per cycle; every stage is a plain register, so nothing stalls.
// Reset: arst_n clears all valid bits and sets the config registers to their defaults.
// The result strobe cannot be held off: each result stands for exactly one cycle.
`default_nettype none
module passive_joint_torque_unit
	import pjt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire pjt_item_t   item,
	output logic             done,
	output pjt_result_t      result
);

	typedef struct packed {
		logic               sat;
		logic signed [30:0] damp;
		logic [1:0][5:0]    n;
	} side_t;

	localparam int NSER = 2 * SER_STEPS;

	// ---------------- configuration registers ----------------
	logic [15:0]        upper_slope_q, lower_slope_q;
	logic signed [15:0] upper_limit_q, lower_limit_q;
	logic signed [31:0] torque_offset_q;
	logic [23:0]        damping_gain_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_slope_q   <= 16'd5120;
			upper_limit_q   <= 16'sd11520;
			lower_slope_q   <= 16'd5120;
			lower_limit_q   <= -16'sd11520;
			torque_offset_q <= 32'sd0;
			damping_gain_q  <= 24'd66;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_UPPER_SLOPE:   upper_slope_q   <= pwdata[15:0];
				REG_UPPER_LIMIT:   upper_limit_q   <= pwdata[15:0];
				REG_LOWER_SLOPE:   lower_slope_q   <= pwdata[15:0];
				REG_LOWER_LIMIT:   lower_limit_q   <= pwdata[15:0];
				REG_TORQUE_OFFSET: torque_offset_q <= pwdata;
				REG_DAMPING_GAIN:  damping_gain_q  <= pwdata[23:0];
				default: ;   // drop writes past the register list
			endcase
		end
	end

	// read back the raw register bits
	always_comb begin
		unique case (paddr[4:2])
			REG_UPPER_SLOPE:   prdata = {16'd0, upper_slope_q};
			REG_UPPER_LIMIT:   prdata = {16'd0, upper_limit_q};
			REG_LOWER_SLOPE:   prdata = {16'd0, lower_slope_q};
			REG_LOWER_LIMIT:   prdata = {16'd0, lower_limit_q};
			REG_TORQUE_OFFSET: prdata = torque_offset_q;
			REG_DAMPING_GAIN:  prdata = {8'd0, damping_gain_q};
			default:           prdata = 32'd0;
		endcase
	end

	// lane 0 is the upper end of the range, lane 1 the lower end
	logic [15:0]        slope_w [2];
	logic signed [15:0] limit_w [2];
	assign slope_w[0] = upper_slope_q;
	assign slope_w[1] = lower_slope_q;
	assign limit_w[0] = upper_limit_q;
	assign limit_w[1] = lower_limit_q;

	// ---------------- valid bits ----------------
	logic [7:1]      vld_s;
	logic [NSER-1:0] vld_ser;
	logic            vld_s30, vld_s31;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			vld_ser <= '0;
			vld_s30 <= 1'b0;
			vld_s31 <= 1'b0;
			done    <= 1'b0;
		end else begin
			vld_s   <= {vld_s[6:1], start && !busy};
			vld_ser <= {vld_ser[NSER-2:0], vld_s[7]};
			vld_s30 <= vld_ser[NSER-1];
			vld_s31 <= vld_s30;
			done    <= vld_s31;
		end
	end

	// ---------------- front stages ----------------
	// s1: limits to radians, damping product
	// s2: angle minus limit, round the damping term
	// s3: slope times difference
	// s4: clamp the exponent argument, add the bias
	// s5: estimate quotient by ln2
	// s6: quotient times ln2
	// s7: remainder with one correction step
	logic signed [15:0] angle_s1;
	logic signed [37:0] limrad_s1 [2];
	logic signed [40:0] dprod_s1;
	logic signed [38:0] diff_s2 [2];
	logic signed [30:0] damp_s2, damp_s3, damp_s4, damp_s5, damp_s6, damp_s7;
	logic signed [55:0] arg_s3 [2];
	logic [44:0]        xp_s4 [2], xp_s5 [2], xp_s6 [2];
	logic               sat_s4, sat_s5, sat_s6, sat_s7;
	logic [37:0]        qm_s5 [2];
	logic [5:0]         q_s6 [2];
	logic [45:0]        prod_s6 [2];
	logic [31:0]        r32_s7 [2];
	logic [5:0]         n_s7 [2];

	logic signed [55:0] xn_c [2], xc_c [2], xb_c [2];
	logic [1:0]         hi_c;
	logic [45:0]        rr_c [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			xn_c[l] = (l == 1) ? -arg_s3[l] : arg_s3[l];
			hi_c[l] = 1'b0;
			if (xn_c[l] > ARG_MAX) begin
				xc_c[l] = ARG_MAX;
				hi_c[l] = 1'b1;
			end else if (xn_c[l] < -ARG_MAX) begin
				xc_c[l] = -ARG_MAX;
			end else begin
				xc_c[l] = xn_c[l];
			end
			xb_c[l] = xc_c[l] + XP_BIAS;
			rr_c[l] = {1'b0, xp_s6[l]} - prod_s6[l];
		end
	end

	always_ff @(posedge clk) begin
		angle_s1 <= $signed(item.joint_angle);
		dprod_s1 <= 41'($signed({1'b0, damping_gain_q}) * $signed(item.joint_speed));
		damp_s2  <= 31'((dprod_s1 + 41'sd512) >>> 10);
		damp_s3  <= damp_s2;
		damp_s4  <= damp_s3;
		damp_s5  <= damp_s4;
		damp_s6  <= damp_s5;
		damp_s7  <= damp_s6;
		sat_s4   <= |hi_c;
		sat_s5   <= sat_s4;
		sat_s6   <= sat_s5;
		sat_s7   <= sat_s6;
		for (int l = 0; l < 2; l++) begin
			limrad_s1[l] <= 38'(limit_w[l] * $signed({1'b0, DEG64_TO_RAD}));
			diff_s2[l]   <= 39'($signed({angle_s1, 19'd0})) - 39'(limrad_s1[l]);
			arg_s3[l]    <= $signed({1'b0, slope_w[l]}) * diff_s2[l];
			xp_s4[l]     <= xb_c[l][44:0];
			qm_s5[l]     <= 38'(xp_s4[l][44:24]) * 38'(RECIP_LN2);
			xp_s5[l]     <= xp_s4[l];
			q_s6[l]      <= qm_s5[l][37:32];
			prod_s6[l]   <= 46'(qm_s5[l][37:32]) * 46'(LN2_Q40);
			xp_s6[l]     <= xp_s5[l];
			if (rr_c[l] >= 46'(LN2_Q40)) begin
				r32_s7[l] <= 32'((rr_c[l] - 46'(LN2_Q40)) >> 8);
				n_s7[l]   <= q_s6[l] + 6'd1;
			end else begin
				r32_s7[l] <= rr_c[l][39:8];
				n_s7[l]   <= q_s6[l];
			end
		end
	end

	// ---------------- Taylor series of e^r ----------------
	// step j handles power k = j + 2 in two stages: A multiplies the last
	// term by r, B multiplies by the reciprocal of k.
	logic [31:0] ph_ser  [SER_STEPS][2];
	logic [31:0] ra_ser  [SER_STEPS][2];
	logic [33:0] suma_ser [SER_STEPS][2];
	logic [64:0] d_ser   [SER_STEPS][2];
	logic [31:0] rb_ser  [SER_STEPS][2];
	logic [33:0] sumb_ser [SER_STEPS][2];
	side_t       side_ser [NSER];

	logic [31:0] term_c [SER_STEPS][2];
	logic [31:0] rin_c  [SER_STEPS][2];
	logic [33:0] sum_c  [SER_STEPS][2];
	logic [31:0] term12_c [2];
	side_t       side_s7;

	always_comb begin
		side_s7.sat  = sat_s7;
		side_s7.damp = damp_s7;
		side_s7.n[0] = n_s7[0];
		side_s7.n[1] = n_s7[1];
		for (int l = 0; l < 2; l++) begin
			term_c[0][l] = r32_s7[l];
			rin_c[0][l]  = r32_s7[l];
			sum_c[0][l]  = (34'd1 << 32) + 34'(r32_s7[l]);
			for (int j = 1; j < SER_STEPS; j++) begin
				term_c[j][l] = 32'(d_ser[j-1][l] >> DIV_SH[j+1]);
				rin_c[j][l]  = rb_ser[j-1][l];
				sum_c[j][l]  = sumb_ser[j-1][l] + 34'(term_c[j][l]);
			end
			term12_c[l] = 32'(d_ser[SER_STEPS-1][l] >> DIV_SH[SER_STEPS+1]);
		end
	end

	always_ff @(posedge clk) begin
		side_ser[0] <= side_s7;
		for (int i = 1; i < NSER; i++) begin
			side_ser[i] <= side_ser[i-1];
		end
		for (int j = 0; j < SER_STEPS; j++) begin
			for (int l = 0; l < 2; l++) begin
				ph_ser[j][l]   <= 32'((64'(term_c[j][l]) * 64'(rin_c[j][l])) >> 32);
				ra_ser[j][l]   <= rin_c[j][l];
				suma_ser[j][l] <= sum_c[j][l];
				d_ser[j][l]    <= 65'(ph_ser[j][l]) * 65'(DIV_MUL[j+2]);
				rb_ser[j][l]   <= ra_ser[j][l];
				sumb_ser[j][l] <= suma_ser[j][l];
			end
		end
	end

	// ---------------- scale by 2^(n-34), sum, saturate ----------------
	logic [33:0]        sum_s30 [2];
	side_t              side_s30, side_s31;
	logic [34:0]        e_s31 [2];
	logic [34:0]        e_c [2];
	logic [5:0]         sh_c [2];
	logic signed [39:0] total_c;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			sh_c[l] = 6'd34 - side_s30.n[l];
			if (side_s30.n[l] >= 6'd35) begin
				e_c[l] = {sum_s30[l], 1'b0};
			end else begin
				e_c[l] = ({1'b0, sum_s30[l]} + (35'd1 << (sh_c[l] - 6'd1))) >> sh_c[l];
			end
		end
		total_c = 40'(torque_offset_q) - 40'(e_s31[0]) + 40'(e_s31[1])
			- 40'(side_s31.damp);
	end

	always_ff @(posedge clk) begin
		side_s30 <= side_ser[NSER-1];
		side_s31 <= side_s30;
		for (int l = 0; l < 2; l++) begin
			sum_s30[l] <= sumb_ser[SER_STEPS-1][l] + 34'(term12_c[l]);
			e_s31[l]   <= e_c[l];
		end
		// clamp to the signed 32-bit range and flag it
		if (total_c > 40'sd2147483647) begin
			result.torque    <= 32'sh7FFFFFFF;
			result.saturated <= 1'b1;
		end else if (total_c < -40'sd2147483648) begin
			result.torque    <= 32'sh80000000;
			result.saturated <= 1'b1;
		end else begin
			result.torque    <= total_c[31:0];
			result.saturated <= side_s31.sat;
		end
	end

endmodule
`default_nettype wire

/* sv/pjt_checker.sv */
`default_nettype none
`include "passive_joint_torque_unit_assert.svh"
module pjt_checker
	import pjt_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [4:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata,
	input wire logic        pready,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done
);

	logic off_sel;
	assign off_sel = psel && (paddr[4:2] == REG_TORQUE_OFFSET);

	`PJT_ASSERT_IMP(a_never_busy, 1'b1, !busy && pready)
	`PJT_ASSERT_IMP(a_fixed_latency, start && !busy, ##PJT_LATENCY done)
	`PJT_ASSERT_IMP(a_no_stray_result, done, $past(start && !busy, PJT_LATENCY))
	`PJT_ASSERT_NXT(a_offset_readback, off_sel && penable && pwrite, !off_sel || prdata == $past(pwdata))

endmodule

bind passive_joint_torque_unit pjt_checker u_pjt_checker (.*);
`default_nettype wire

/* sim/passive_joint_torque_unit_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module passive_joint_torque_unit_tb;
	import pjt_pkg::*;

	// indexes with no register behind them: writes must be dropped
	localparam logic [2:0] REG_SPARE = 3'd6;
	localparam logic [2:0] REG_SPARE_TOP = 3'd7;
	localparam longint unsigned LN2_VAL = 64'hB17217F7D2;
	localparam longint signed DEG64_RAD = 1171271;
	localparam longint signed ARG_LIMIT = 64'sd12 <<< 40;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic start;
	logic busy;
	pjt_item_t item;
	logic done;
	pjt_result_t result;

	passive_joint_torque_unit uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .item(item),
		.done(done), .result(result)
	);

	// shadow copy of the register file, used by the torque predictor
	logic [15:0] upper_slope_q, lower_slope_q;
	logic signed [15:0] upper_limit_q, lower_limit_q;
	logic signed [31:0] offset_q;
	logic [23:0] damping_q;

	pjt_result_t torque_queue[$];
	int mismatches;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// exp of a Q.40 argument, in Q16.16; hit is set when the top clamp engages
	function automatic longint unsigned exp_q16(longint signed x, inout bit hit);
		longint unsigned xp, n, r32, sum, term;
		int sh;
		if (x > ARG_LIMIT) begin
			x = ARG_LIMIT;
			hit = 1'b1;
		end
		if (x < -ARG_LIMIT)
			x = -ARG_LIMIT;
		xp = longint'(x) + 18 * LN2_VAL;
		n = xp / LN2_VAL;
		r32 = (xp % LN2_VAL) >> 8;
		sum = 64'd1 << 32;
		term = 64'd1 << 32;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * r32) >> 32) / k;
			sum += term;
		end
		sh = int'(n) - 34;
		if (sh >= 0)
			return sum << sh;
		sh = -sh;
		return (sum + (64'd1 << (sh - 1))) >> sh;
	endfunction

	function automatic pjt_result_t predict_torque(pjt_item_t it);
		longint signed ang, spd, diff_up, diff_lo, e_up, e_lo, damp, total;
		bit hit;
		pjt_result_t r;
		hit = 1'b0;
		ang = longint'(it.joint_angle) * 524288;
		spd = longint'(it.joint_speed);
		diff_up = ang - longint'(upper_limit_q) * DEG64_RAD;
		diff_lo = ang - longint'(lower_limit_q) * DEG64_RAD;
		e_up = exp_q16(longint'({48'd0, upper_slope_q}) * diff_up, hit);
		e_lo = exp_q16(-(longint'({48'd0, lower_slope_q}) * diff_lo), hit);
		// arithmetic shift floors, so this rounds half toward plus infinity
		damp = (longint'({40'd0, damping_q}) * spd + 512) >>> 10;
		total = longint'(offset_q) - e_up + e_lo - damp;
		if (total > 64'sd2147483647) begin
			total = 64'sd2147483647;
			hit = 1'b1;
		end else if (total < -64'sd2147483648) begin
			total = -64'sd2147483648;
			hit = 1'b1;
		end
		r.torque = total[31:0];
		r.saturated = hit;
		return r;
	endfunction

	// compare every strobed result against the oldest pending prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (torque_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result torque=%0d sat=%0b",
						result.torque, result.saturated);
			end else begin
				pjt_result_t want;
				want = torque_queue.pop_front();
				if (result.torque !== want.torque || result.saturated !== want.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected torque=%0d sat=%0b, got torque=%0d sat=%0b",
							want.torque, want.saturated, result.torque, result.saturated);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("passive_joint_torque_unit_tb NOT OK");
			$finish;
		end
	end

	// write one register through the APB port and mirror it in the shadow copy
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_UPPER_SLOPE:   upper_slope_q = value[15:0];
			REG_UPPER_LIMIT:   upper_limit_q = value[15:0];
			REG_LOWER_SLOPE:   lower_slope_q = value[15:0];
			REG_LOWER_LIMIT:   lower_limit_q = value[15:0];
			REG_TORQUE_OFFSET: offset_q = value;
			REG_DAMPING_GAIN:  damping_q = value[23:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [15:0] us, logic [15:0] ul, logic [15:0] ls,
			logic [15:0] ll, logic [31:0] off, logic [23:0] dg);
		write_reg(REG_UPPER_SLOPE, {16'd0, us});
		write_reg(REG_UPPER_LIMIT, {{16{ul[15]}}, ul});
		write_reg(REG_LOWER_SLOPE, {16'd0, ls});
		write_reg(REG_LOWER_LIMIT, {{16{ll[15]}}, ll});
		write_reg(REG_TORQUE_OFFSET, off);
		write_reg(REG_DAMPING_GAIN, {8'd0, dg});
	endtask

	// hold the request until the block takes it, then log the prediction
	task automatic send_request(logic [15:0] ang, logic [15:0] spd);
		pjt_item_t it;
		it.joint_angle = ang;
		it.joint_speed = spd;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		torque_queue.push_back(predict_torque(it));
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// drop start, wait for every pending result, then let the pipe settle
	task automatic drain();
		start <= 1'b0;
		while (torque_queue.size() != 0)
			@(posedge clk);
		repeat (PJT_LATENCY + 4) @(posedge clk);
	endtask

	// now and then pause before the next request, about 14 times in a hundred
	task automatic maybe_idle(bit quiet);
		if (!quiet && $urandom_range(99) < 14)
			pause(1);
	endtask

	// angle near one of the limits (where the exponentials wake up) or random
	function automatic logic [15:0] pick_angle();
		longint signed lim, a;
		case ($urandom_range(3))
			0: lim = longint'(upper_limit_q);
			1: lim = longint'(lower_limit_q);
			default: return 16'($urandom);
		endcase
		// 1/64 degree to Q3.13 radians, roughly, plus jitter
		a = (lim * 8192 * 314159) / (11520 * 100000) + $signed($urandom_range(2000)) - 1000;
		if (a > 32767) a = 32767;
		if (a < -32768) a = -32768;
		return a[15:0];
	endfunction

	task automatic test_defaults();
		logic [15:0] corners[5];
		corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
		foreach (corners[i]) begin
			send_request(corners[i], corners[4 - i]);
			maybe_idle(1'b0);
		end
		// both exponentials at the edge of the range, speed at both extremes
		send_request(16'sd25736, 16'h7FFF);
		send_request(-16'sd25736, 16'h8000);
		// hold off until the pipe is empty
		drain();
	endtask

	task automatic test_large_argument();
		// steep slopes and tight limits push both exponent arguments past the clamp
		write_all(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 32'd0, 24'd0);
		send_request(16'h7FFF, 16'd0);
		send_request(16'h8000, 16'd0);
		send_request(16'd0, 16'd0);
		send_request(16'd1, 16'd0);
		send_request(16'hFFFF, 16'd0);
		drain();
	endtask

	task automatic test_overflow();
		write_all(16'd0, 16'sd23040, 16'd0, -16'sd23040, 32'h7FFF_FFFF, 24'hFF_FFFF);
		send_request(16'd0, 16'h8000);
		send_request(16'd0, 16'h7FFF);
		drain();
		write_all(16'd0, -16'sd23040, 16'd0, 16'sd23040, 32'h8000_0000, 24'hFF_FFFF);
		send_request(16'd0, 16'h7FFF);
		send_request(16'd0, 16'h8000);
		// a write to a missing register must change nothing
		drain();
		write_reg(REG_SPARE, 32'hDEAD_BEEF);
		write_reg(REG_SPARE_TOP, 32'h1234_5678);
		send_request(16'h4000, 16'h0400);
		// limits beyond the stated range
		drain();
		write_all(16'd5120, 16'h7FFF, 16'd5120, 16'h8000, 32'd0, 24'd66);
		send_request(16'h7FFF, 16'h7FFF);
		send_request(16'h8000, 16'h8000);
		drain();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			// retune the registers between phases
			if (i % 150 == 0) begin
				drain();
				write_all(16'($urandom_range(65535) >> $urandom_range(8)),
					16'($signed($urandom_range(46080)) - 23040),
					16'($urandom_range(65535) >> $urandom_range(8)),
					16'($signed($urandom_range(46080)) - 23040),
					($urandom_range(3) == 0) ? $urandom : ($urandom >>> $urandom_range(31)),
					24'($urandom >> $urandom_range(8, 31)));
			end
			send_request(pick_angle(), 16'($urandom));
			// one long stretch with back-to-back requests
			maybe_idle(i >= 400 && i < 600);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		item = '0;
		mismatches = 0;
		cycles = 0;
		upper_slope_q = 16'd5120;
		upper_limit_q = 16'sd11520;
		lower_slope_q = 16'd5120;
		lower_limit_q = -16'sd11520;
		offset_q = 32'sd0;
		damping_q = 24'd66;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_large_argument();
		test_overflow();
		test_random(1130);

		if (torque_queue.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("passive_joint_torque_unit_tb OK");
		else
			$display("passive_joint_torque_unit_tb NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
